/* design/ulcr_pkg.sv */
// ============================================================================
// ulcr_pkg
// Shared types and constants of the uart led command responder.
// ============================================================================
package ulcr_pkg;

    // default ring size in bytes, a power of two from 8 to 64
    localparam int QUEUE_DEPTH_DEFAULT = 64;

    // event codes carried in the opcode field
    localparam logic [1:0] OP_RX_BYTE   = 2'd0;
    localparam logic [1:0] OP_TX_DONE   = 2'd1;
    localparam logic [1:0] OP_READ_BYTE = 2'd2;

    // characters of the command protocol
    localparam logic [7:0] CHAR_R  = 8'h52;
    localparam logic [7:0] CHAR_G  = 8'h47;
    localparam logic [7:0] CHAR_1  = 8'h31;
    localparam logic [7:0] CHAR_0  = 8'h30;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // bytes in one response: letter, digit, cr, lf
    localparam int RESP_LEN = 4;

    // armed command
    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_RED   = 2'd1,
        CMD_GREEN = 2'd2
    } cmd_t;

endpackage

/* design/ulcr_queue_ram.sv */
// ============================================================================
// ulcr_queue_ram
// Transmit ring storage: one write port, one read port with registered data.
// ============================================================================
module ulcr_queue_ram #(
    parameter int DEPTH = ulcr_pkg::QUEUE_DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/uart_led_command_responder_top.sv */
// ============================================================================
// uart_led_command_responder_top
// Command parser for R/G led commands with a transmit ring and chunk requests.
// ============================================================================
// One event is taken per transfer on the s_ side and answered by exactly one
// result on the m_ side, held in an output register; a new event is taken only
// while that register is empty or in the cycle its waiting result is taken.
// An event that queues a response holds off new events until all four of its
// bytes are in the ring, since the ring memory's single write port stores one
// response byte per cycle. A queue read returns its byte with the result, from
// the registered memory port.
// The ring contents are undefined after reset and are not cleared; QUEUE_DEPTH
// must be a power of two.
module uart_led_command_responder_top #(
    parameter int QUEUE_DEPTH = ulcr_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input events
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // opcode[1:0], rx_byte[9:2], read_index[15:10]
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // red_pin_level[0], green_pin_level[1],
                                  // transfer_start[2], transfer_offset[8:3],
                                  // transfer_length[14:9], response_dropped[15],
                                  // read_data[23:16]
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    // input fields
    logic [1:0] in_opcode;
    logic [7:0] in_rx_byte;
    logic [5:0] in_read_index;

    assign in_opcode     = s_tdata[1:0];
    assign in_rx_byte    = s_tdata[9:2];
    assign in_read_index = s_tdata[15:10];

    // control state
    ulcr_pkg::cmd_t armed_reg, armed_next;
    logic [PW-1:0]  wp_reg, wp_next;
    logic [PW-1:0]  rp_reg, rp_next;
    logic           sending_reg, sending_next;
    logic [PW-1:0]  chunk_reg, chunk_next;
    logic           red_reg, red_next;
    logic           green_reg, green_next;

    // response byte sequencer
    logic [1:0]     seq_cnt_reg, seq_cnt_next;
    logic [PW-1:0]  seq_addr_reg, seq_addr_next;
    logic [7:0]     seq_digit_reg, seq_digit_next;

    // result register
    logic           m_valid_reg, m_valid_next;
    logic           res_start_reg;
    logic [5:0]     res_offset_reg;
    logic [5:0]     res_length_reg;
    logic           res_dropped_reg;
    logic           res_read_reg;

    logic           accept;
    logic           seq_busy;
    logic [PW-1:0]  room_left;
    logic           queue_wr;
    logic [7:0]     letter;
    logic           check_start;
    logic           start;
    logic           dropped;

    logic           wr_en;
    logic [PW-1:0]  wr_addr;
    logic [7:0]     wr_data;
    logic           rd_en;
    logic [PW-1:0]  rd_addr;
    logic [7:0]     rd_data;

    // hold off events while response bytes are still going into the ring
    assign seq_busy = (seq_cnt_reg != 2'd0);
    assign s_tready = !seq_busy && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // free bytes in the ring, one slot kept unused
    assign room_left = rp_reg - wp_reg - PW'(1);

    // event handling and chunk request
    always_comb begin
        armed_next   = armed_reg;
        wp_next      = wp_reg;
        rp_next      = rp_reg;
        sending_next = sending_reg;
        chunk_next   = chunk_reg;
        red_next     = red_reg;
        green_next   = green_reg;
        queue_wr     = 1'b0;
        letter       = ulcr_pkg::CHAR_R;
        check_start  = 1'b0;
        start        = 1'b0;
        dropped      = 1'b0;
        if (accept) begin
            case (in_opcode)
                ulcr_pkg::OP_RX_BYTE: begin
                    if (in_rx_byte == ulcr_pkg::CHAR_R) begin
                        armed_next = ulcr_pkg::CMD_RED;
                    end else if (in_rx_byte == ulcr_pkg::CHAR_G) begin
                        armed_next = ulcr_pkg::CMD_GREEN;
                    end else if ((in_rx_byte == ulcr_pkg::CHAR_1 ||
                                  in_rx_byte == ulcr_pkg::CHAR_0) &&
                                 (armed_reg == ulcr_pkg::CMD_RED ||
                                  armed_reg == ulcr_pkg::CMD_GREEN)) begin
                        if (armed_reg == ulcr_pkg::CMD_RED) begin
                            red_next = (in_rx_byte != ulcr_pkg::CHAR_1);
                            letter   = ulcr_pkg::CHAR_R;
                        end else begin
                            green_next = (in_rx_byte != ulcr_pkg::CHAR_1);
                            letter     = ulcr_pkg::CHAR_G;
                        end
                        armed_next = ulcr_pkg::CMD_NONE;
                        if ({1'b0, room_left} < (PW+1)'(ulcr_pkg::RESP_LEN)) begin
                            dropped = 1'b1;
                        end else begin
                            queue_wr    = 1'b1;
                            wp_next     = wp_reg + PW'(ulcr_pkg::RESP_LEN);
                            check_start = 1'b1;
                        end
                    end else if (in_rx_byte != ulcr_pkg::CHAR_CR &&
                                 in_rx_byte != ulcr_pkg::CHAR_LF) begin
                        armed_next = ulcr_pkg::CMD_NONE;
                    end
                end
                ulcr_pkg::OP_TX_DONE: begin
                    if (sending_reg) begin
                        rp_next      = rp_reg + chunk_reg;
                        sending_next = 1'b0;
                        check_start  = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        // request a chunk that stops at write pointer or at the ring end
        if (check_start && !sending_next && (rp_next != wp_next)) begin
            start        = 1'b1;
            sending_next = 1'b1;
            if (wp_next > rp_next) begin
                chunk_next = wp_next - rp_next;
            end else begin
                chunk_next = PW'(0) - rp_next;
            end
        end
    end

    // sequencer for the digit, cr and lf bytes after the letter
    always_comb begin
        seq_cnt_next   = seq_cnt_reg;
        seq_addr_next  = seq_addr_reg;
        seq_digit_next = seq_digit_reg;
        wr_en          = 1'b0;
        wr_addr        = seq_addr_reg;
        wr_data        = ulcr_pkg::CHAR_LF;
        if (queue_wr) begin
            wr_en          = 1'b1;
            wr_addr        = wp_reg;
            wr_data        = letter;
            seq_cnt_next   = 2'd3;
            seq_addr_next  = wp_reg + PW'(1);
            seq_digit_next = in_rx_byte;
        end else if (seq_busy) begin
            wr_en         = 1'b1;
            seq_cnt_next  = seq_cnt_reg - 2'd1;
            seq_addr_next = seq_addr_reg + PW'(1);
            case (seq_cnt_reg)
                2'd3:    wr_data = seq_digit_reg;
                2'd2:    wr_data = ulcr_pkg::CHAR_CR;
                default: wr_data = ulcr_pkg::CHAR_LF;
            endcase
        end
    end

    // queue read for dma
    assign rd_en   = accept && (in_opcode == ulcr_pkg::OP_READ_BYTE);
    assign rd_addr = PW'(in_read_index);

    // output slot handshake
    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg   <= ulcr_pkg::CMD_NONE;
            wp_reg      <= '0;
            rp_reg      <= '0;
            sending_reg <= 1'b0;
            chunk_reg   <= '0;
            red_reg     <= 1'b1;
            green_reg   <= 1'b1;
            seq_cnt_reg <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            armed_reg   <= armed_next;
            wp_reg      <= wp_next;
            rp_reg      <= rp_next;
            sending_reg <= sending_next;
            chunk_reg   <= chunk_next;
            red_reg     <= red_next;
            green_reg   <= green_next;
            seq_cnt_reg <= seq_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        seq_addr_reg  <= seq_addr_next;
        seq_digit_reg <= seq_digit_next;
        if (accept) begin
            res_start_reg   <= start;
            res_offset_reg  <= start ? 6'(rp_next) : 6'd0;
            res_length_reg  <= start ? 6'(chunk_next) : 6'd0;
            res_dropped_reg <= dropped;
            res_read_reg    <= rd_en;
        end
    end

    ulcr_queue_ram #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (PW)
    ) u_queue_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // result packing, pin levels always show the current state
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {res_read_reg ? rd_data : 8'd0,
                       res_dropped_reg,
                       res_length_reg,
                       res_offset_reg,
                       res_start_reg,
                       green_reg,
                       red_reg};

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Self-checking bench for the uart led command responder. Received bytes,
// chunk-done events and queue reads go in on the s_ stream; every transfer on
// the m_ stream is checked field by field against a cycle-free prediction of
// the led pins, the transmit ring and its chunk requests. Directed cases come
// first, then a full ring, a long receiver hold-off and random traffic under
// three idle patterns.
// ============================================================================
module testbench;

    localparam int DEPTH            = ulcr_pkg::QUEUE_DEPTH_DEFAULT;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int WATCHDOG_LIMIT   = 3000;
    localparam int DRAIN_CYCLES     = 20;

    // opcode the block does not define
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef logic [$clog2(DEPTH)-1:0] ptr_t;

    // result fields, lowest bit last
    typedef struct packed {
        logic [7:0] read_data;
        logic       response_dropped;
        logic [5:0] transfer_length;
        logic [5:0] transfer_offset;
        logic       transfer_start;
        logic       green_pin_level;
        logic       red_pin_level;
    } status_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // opcode[1:0], rx_byte[9:2], read_index[15:10]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // red[0], green[1], start[2], offset[8:3],
                            // length[14:9], dropped[15], read_data[23:16]

    // predicted responder state
    ulcr_pkg::cmd_t armed;
    ptr_t        wr_ptr;
    ptr_t        rd_ptr;
    logic        tx_busy;
    ptr_t        chunk_len;
    logic [7:0]  ring_bytes [DEPTH];
    logic [DEPTH-1:0] ring_written;
    logic        red_level;
    logic        green_level;

    status_t     predicted_status [$];
    int          mismatch_count;
    int          items_sent;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          stall_cycles;
    int          hold_left;
    bit          hold_request;

    uart_led_command_responder_top #(
        .QUEUE_DEPTH (DEPTH)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    // next status of the responder for one event, updates predicted state
    function automatic status_t responder_predict(logic [1:0] op, logic [7:0] ch,
                                                  logic [5:0] idx);
        status_t    st;
        ptr_t       free_bytes;
        logic [7:0] letter;
        logic       try_chunk;
        st        = '0;
        try_chunk = 1'b0;
        case (op)
            ulcr_pkg::OP_RX_BYTE: begin
                if (ch == ulcr_pkg::CHAR_R) begin
                    armed = ulcr_pkg::CMD_RED;
                end else if (ch == ulcr_pkg::CHAR_G) begin
                    armed = ulcr_pkg::CMD_GREEN;
                end else if ((ch == ulcr_pkg::CHAR_1 || ch == ulcr_pkg::CHAR_0) &&
                             armed != ulcr_pkg::CMD_NONE) begin
                    // active-low pin: digit one lights it
                    if (armed == ulcr_pkg::CMD_RED) begin
                        red_level = (ch == ulcr_pkg::CHAR_0);
                        letter    = ulcr_pkg::CHAR_R;
                    end else begin
                        green_level = (ch == ulcr_pkg::CHAR_0);
                        letter      = ulcr_pkg::CHAR_G;
                    end
                    armed      = ulcr_pkg::CMD_NONE;
                    free_bytes = rd_ptr - wr_ptr - ptr_t'(1);
                    if (free_bytes < ptr_t'(ulcr_pkg::RESP_LEN)) begin
                        st.response_dropped = 1'b1;
                    end else begin
                        ring_bytes[wr_ptr]             = letter;
                        ring_bytes[ptr_t'(wr_ptr + 1)] = ch;
                        ring_bytes[ptr_t'(wr_ptr + 2)] = ulcr_pkg::CHAR_CR;
                        ring_bytes[ptr_t'(wr_ptr + 3)] = ulcr_pkg::CHAR_LF;
                        for (int k = 0; k < ulcr_pkg::RESP_LEN; k++) begin
                            ring_written[ptr_t'(wr_ptr + k)] = 1'b1;
                        end
                        wr_ptr    = ptr_t'(wr_ptr + ulcr_pkg::RESP_LEN);
                        try_chunk = 1'b1;
                    end
                end else if (ch != ulcr_pkg::CHAR_CR && ch != ulcr_pkg::CHAR_LF) begin
                    armed = ulcr_pkg::CMD_NONE;
                end
            end
            ulcr_pkg::OP_TX_DONE: begin
                // done while idle is ignored
                if (tx_busy) begin
                    rd_ptr    = rd_ptr + chunk_len;
                    tx_busy   = 1'b0;
                    try_chunk = 1'b1;
                end
            end
            ulcr_pkg::OP_READ_BYTE: begin
                st.read_data = ring_bytes[ptr_t'(idx)];
            end
            default: ;
        endcase
        // chunk runs to the write pointer or to the ring end on wrap
        if (try_chunk && !tx_busy && rd_ptr != wr_ptr) begin
            if (wr_ptr > rd_ptr) begin
                chunk_len = wr_ptr - rd_ptr;
            end else begin
                chunk_len = ptr_t'(DEPTH - int'(rd_ptr));
            end
            tx_busy            = 1'b1;
            st.transfer_start  = 1'b1;
            st.transfer_offset = rd_ptr;
            st.transfer_length = chunk_len;
        end
        st.red_pin_level   = red_level;
        st.green_pin_level = green_level;
        return st;
    endfunction

    // one event transfer on the s_ side, with random idle before it
    task automatic send_event(input logic [1:0] op, input logic [7:0] ch,
                              input logic [5:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {idx, ch, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted_status.push_back(responder_predict(op, ch, idx));
        items_sent++;
    endtask

    task automatic send_rx(input logic [7:0] ch);
        send_event(ulcr_pkg::OP_RX_BYTE, ch, 6'($urandom));
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // compare each result transfer with the oldest prediction
    always @(posedge aclk) begin
        status_t got;
        status_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready) begin
            got = m_tdata;
            if (predicted_status.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                mismatch_count++;
            end else begin
                want = predicted_status.pop_front();
                check_field("red_pin_level", 32'(want.red_pin_level),
                            32'(got.red_pin_level));
                check_field("green_pin_level", 32'(want.green_pin_level),
                            32'(got.green_pin_level));
                check_field("transfer_start", 32'(want.transfer_start),
                            32'(got.transfer_start));
                check_field("transfer_offset", 32'(want.transfer_offset),
                            32'(got.transfer_offset));
                check_field("transfer_length", 32'(want.transfer_length),
                            32'(got.transfer_length));
                check_field("response_dropped", 32'(want.response_dropped),
                            32'(got.response_dropped));
                check_field("read_data", 32'(want.read_data), 32'(got.read_data));
            end
        end
    end

    // receiver ready, random or held off for a long stretch
    always @(posedge aclk) begin
        if (hold_request) begin
            hold_left    = HOLD_OFF_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid === 1'b1 && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // commands, done events, queue reads and the special cases
    task automatic test_directed();
        send_rx(ulcr_pkg::CHAR_G);
        send_rx(ulcr_pkg::CHAR_1);
        // cr and lf keep the armed command
        send_rx(ulcr_pkg::CHAR_R);
        send_rx(ulcr_pkg::CHAR_CR);
        send_rx(ulcr_pkg::CHAR_LF);
        send_rx(ulcr_pkg::CHAR_1);
        send_event(ulcr_pkg::OP_TX_DONE, 8'h00, 6'd0);
        send_event(ulcr_pkg::OP_TX_DONE, 8'hFF, 6'd63);
        // done while idle
        send_event(ulcr_pkg::OP_TX_DONE, 8'h00, 6'd0);
        send_event(ulcr_pkg::OP_READ_BYTE, 8'hFF, 6'd0);
        send_event(ulcr_pkg::OP_READ_BYTE, 8'h00, 6'd7);
        // unknown opcode does not arm, so the digit finds nothing armed
        send_event(OP_UNUSED, ulcr_pkg::CHAR_R, 6'd63);
        send_rx(ulcr_pkg::CHAR_1);
        // another byte disarms
        send_rx(ulcr_pkg::CHAR_R);
        send_rx("X");
        send_rx(ulcr_pkg::CHAR_1);
        // a second letter replaces the first
        send_rx(ulcr_pkg::CHAR_G);
        send_rx(ulcr_pkg::CHAR_R);
        send_rx(ulcr_pkg::CHAR_0);
        send_event(ulcr_pkg::OP_RX_BYTE, 8'h00, 6'd63);
        send_event(ulcr_pkg::OP_RX_BYTE, 8'hFF, 6'd0);
        send_event(ulcr_pkg::OP_TX_DONE, 8'h00, 6'd0);
    endtask

    // fill the ring until a response is dropped, then drain it
    task automatic test_ring_full();
        for (int n = 0; n < 17; n++) begin
            send_rx(ulcr_pkg::CHAR_G);
            send_rx(n[0] ? ulcr_pkg::CHAR_0 : ulcr_pkg::CHAR_1);
        end
        while (tx_busy) send_event(ulcr_pkg::OP_TX_DONE, 8'($urandom), 6'($urandom));
    endtask

    // receiver holds off while the sender keeps offering commands
    task automatic test_output_stall();
        int saved_idle;
        saved_idle    = send_idle_pct;
        send_idle_pct = 0;
        hold_request  = 1'b1;
        for (int n = 0; n < 20; n++) begin
            send_rx($urandom_range(1) ? ulcr_pkg::CHAR_R : ulcr_pkg::CHAR_G);
            send_rx($urandom_range(1) ? ulcr_pkg::CHAR_1 : ulcr_pkg::CHAR_0);
        end
        send_idle_pct = saved_idle;
    endtask

    // mostly well-formed commands with random content, plus noise
    task automatic test_random(input int count, input int done_pct);
        int         stop_at;
        int         pick;
        logic [5:0] idx;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < done_pct) begin
                send_event(ulcr_pkg::OP_TX_DONE, 8'($urandom), 6'($urandom));
            end else if (pick < 60) begin
                send_rx($urandom_range(1) ? ulcr_pkg::CHAR_R : ulcr_pkg::CHAR_G);
                if ($urandom_range(4) == 0) begin
                    send_rx($urandom_range(1) ? ulcr_pkg::CHAR_CR : ulcr_pkg::CHAR_LF);
                end
                // broken sequence
                if ($urandom_range(9) == 0) send_rx(8'($urandom));
                send_rx($urandom_range(1) ? ulcr_pkg::CHAR_1 : ulcr_pkg::CHAR_0);
            end else if (pick < 78) begin
                // only entries already written are read
                if (ring_written == '0) begin
                    send_rx(8'($urandom));
                end else begin
                    do idx = 6'($urandom_range(DEPTH - 1)); while (!ring_written[idx]);
                    send_event(ulcr_pkg::OP_READ_BYTE, 8'($urandom), idx);
                end
            end else if (pick < 90) begin
                send_rx(8'($urandom));
            end else if (pick < 95) begin
                send_event(OP_UNUSED, 8'($urandom), 6'($urandom));
            end else begin
                send_rx($urandom_range(1) ? ulcr_pkg::CHAR_1 : ulcr_pkg::CHAR_0);
            end
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        hold_request   = 1'b0;
        hold_left      = 0;
        stall_cycles   = 0;
        mismatch_count = 0;
        items_sent     = 0;
        armed          = ulcr_pkg::CMD_NONE;
        wr_ptr         = '0;
        rd_ptr         = '0;
        tx_busy        = 1'b0;
        chunk_len      = '0;
        ring_written   = '0;
        red_level      = 1'b1;
        green_level    = 1'b1;
        for (int k = 0; k < DEPTH; k++) ring_bytes[k] = 8'h00;
        send_idle_pct  = 30;
        recv_idle_pct  = 82;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_ring_full();
        test_random(500, 20);

        send_idle_pct = 82;
        recv_idle_pct = 30;
        test_random(500, 8);
        test_output_stall();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(500, 30);

        // wait for the last results, then a little longer for strays
        s_tvalid <= 1'b0;
        while (predicted_status.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
